// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies a delayed consequent, the delay set by n
`define ASSERT_DELAYED(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/chbe_pkg.sv
// ----------------------------------------------------------------------------
// chbe_pkg
// shared types, codes and fixed-point helpers of the cubic basis evaluator
// ----------------------------------------------------------------------------
package chbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int OUT_W     = 20;
  localparam int WIDE_W    = 32;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [IN_W-1:0]   coord_t;
  typedef logic signed [OUT_W-1:0]  comp_t;

  localparam wide_t ONE     = wide_t'(1) <<< FRAC_BITS;
  localparam wide_t QUARTER = ONE / 4;
  localparam wide_t OUT_MAX = (wide_t'(1) <<< (OUT_W - 1)) - 1;
  localparam wide_t OUT_MIN = -(wide_t'(1) <<< (OUT_W - 1));
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  localparam logic [2:0] FUNC_VALUE = 3'd0;
  localparam logic [2:0] FUNC_GRAD  = 3'd1;
  localparam logic [2:0] FUNC_CURL  = 3'd2;
  localparam logic [2:0] FUNC_X     = 3'd3;
  localparam logic [2:0] FUNC_Y     = 3'd4;
  localparam logic [2:0] FUNC_Z     = 3'd5;

  localparam logic [2:0] ELEM_LINE = 3'd0;
  localparam logic [2:0] ELEM_TRI  = 3'd1;
  localparam logic [2:0] ELEM_TET  = 3'd3;

  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_FACET = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_NUM = 2'd1;
  localparam logic [1:0] ST_UNSUPP  = 2'd2;
  localparam logic [1:0] ST_NOT_APP = 2'd3;

  typedef enum logic [3:0] {
    F_LINE_E1 = 4'd0,
    F_TRI_E1  = 4'd1,
    F_TRI_E2  = 4'd2,
    F_TRI_E3  = 4'd3,
    F_TET_E1  = 4'd4,
    F_TET_E2  = 4'd5,
    F_TET_E3  = 4'd6,
    F_TET_E4  = 4'd7,
    F_TET_E5  = 4'd8,
    F_TET_E6  = 4'd9,
    F_TRI_F1  = 4'd10,
    F_TET_F1  = 4'd11,
    F_TET_F2  = 4'd12,
    F_TET_F3  = 4'd13,
    F_TET_F4  = 4'd14
  } fsel_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] func;
    fsel_t      fsel;
    logic       negate;
    logic [1:0] status;
  } ctl_t;

  typedef struct packed {
    ctl_t  ctl;
    wide_t u;
    wide_t v;
    wide_t w;
    wide_t uu;
    wide_t uv;
    wide_t uw;
    wide_t vv;
    wide_t vw;
    wide_t ww;
    wide_t p1;
    wide_t c;
  } s1_t;

  typedef struct packed {
    ctl_t  ctl;
    wide_t s;
    wide_t g0;
    wide_t g1;
    wide_t g2;
  } s2_t;

  // rounded fixed-point product, floor((a*b + half) / 2^F)
  function automatic wide_t pm(wide_t a, wide_t b);
    logic signed [63:0] p;
    p = a * b + HALF;
    return wide_t'(p >>> FRAC_BITS);
  endfunction

endpackage

// File: hw/rtl/chbe_prod.sv
// ----------------------------------------------------------------------------
// chbe_prod
// first stage: request decode, coordinate squares and first cubic product
// ----------------------------------------------------------------------------
module chbe_prod (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           func,
  input  logic [2:0]           element_type,
  input  logic [1:0]           entity_kind,
  input  logic [2:0]           entity_number,
  input  logic                 edge_reversed,
  input  chbe_pkg::coord_t     coord_u,
  input  chbe_pkg::coord_t     coord_v,
  input  chbe_pkg::coord_t     coord_w,
  output chbe_pkg::s1_t        s1
);
  import chbe_pkg::*;

  wide_t u, v, w, l2, l3, a, b, c;
  fsel_t fsel;
  logic [1:0] status;

  assign u  = wide_t'(coord_u);
  assign v  = wide_t'(coord_v);
  assign w  = wide_t'(coord_w);
  assign l2 = ONE - u - v;
  assign l3 = ONE - u - v - w;

  always_comb begin
    status = ST_OK;
    fsel   = F_LINE_E1;
    if (!(element_type inside {ELEM_LINE, ELEM_TRI, ELEM_TET})) begin
      status = ST_UNSUPP;
    end else if (entity_kind > KIND_FACET ||
                 (entity_kind == KIND_FACET && element_type == ELEM_LINE)) begin
      status = ST_NOT_APP;
    end else if (entity_kind == KIND_EDGE) begin
      case (element_type)
        ELEM_LINE: begin
          if (entity_number != 3'd1) status = ST_BAD_NUM;
          fsel = F_LINE_E1;
        end
        ELEM_TRI: begin
          if (entity_number inside {[3'd1:3'd3]}) fsel = fsel_t'(entity_number);
          else status = ST_BAD_NUM;
        end
        default: begin
          if (entity_number inside {[3'd1:3'd6]})
            fsel = fsel_t'(4'(entity_number) + 4'd3);
          else status = ST_BAD_NUM;
        end
      endcase
    end else begin
      case (element_type)
        ELEM_TRI: begin
          if (entity_number != 3'd1) status = ST_BAD_NUM;
          fsel = F_TRI_F1;
        end
        default: begin
          if (entity_number inside {[3'd1:3'd4]})
            fsel = fsel_t'(4'(entity_number) + 4'd10);
          else status = ST_BAD_NUM;
        end
      endcase
    end
    if (status == ST_OK && func > FUNC_Z) status = ST_NOT_APP;
  end

  // factors of the cubic, taken in written order
  always_comb begin
    case (fsel)
      F_LINE_E1: begin a = ONE - u; b = ONE + u; c = -u; end
      F_TRI_E1:  begin a = l2; b = u; c = ONE - 2 * u - v; end
      F_TRI_E2:  begin a = l2; b = v; c = ONE - u - 2 * v; end
      F_TRI_E3:  begin a = u;  b = v; c = u - v; end
      F_TET_E1:  begin a = l3; b = u; c = ONE - 2 * u - v - w; end
      F_TET_E2:  begin a = l3; b = v; c = ONE - u - 2 * v - w; end
      F_TET_E3:  begin a = l3; b = w; c = ONE - u - v - 2 * w; end
      F_TET_E4:  begin a = u;  b = v; c = u - v; end
      F_TET_E5:  begin a = u;  b = w; c = u - w; end
      F_TET_E6:  begin a = v;  b = w; c = v - w; end
      F_TRI_F1:  begin a = l2; b = u; c = v; end
      F_TET_F1:  begin a = l3; b = u; c = w; end
      F_TET_F2:  begin a = l3; b = v; c = u; end
      F_TET_F3:  begin a = l3; b = w; c = v; end
      default:   begin a = u;  b = v; c = w; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.ctl.valid <= 1'b0;
    end else begin
      s1.ctl.valid <= start;
    end
    s1.ctl.func   <= func;
    s1.ctl.fsel   <= fsel;
    s1.ctl.negate <= edge_reversed && entity_kind == KIND_EDGE;
    s1.ctl.status <= status;
    s1.u  <= u;
    s1.v  <= v;
    s1.w  <= w;
    s1.uu <= pm(u, u);
    s1.uv <= pm(u, v);
    s1.uw <= pm(u, w);
    s1.vv <= pm(v, v);
    s1.vw <= pm(v, w);
    s1.ww <= pm(w, w);
    s1.p1 <= pm(a, b);
    s1.c  <= c;
  end

endmodule

// File: hw/rtl/chbe_grad.sv
// ----------------------------------------------------------------------------
// chbe_grad
// second stage: second cubic product and gradient sums
// ----------------------------------------------------------------------------
module chbe_grad (
  input  logic          clk,
  input  logic          rst,
  input  chbe_pkg::s1_t s1,
  output chbe_pkg::s2_t s2
);
  import chbe_pkg::*;

  wide_t s, g0, g1, g2, prod;
  wide_t u, v, w, uu, uv, uw, vv, vw, ww;

  assign u  = s1.u;
  assign v  = s1.v;
  assign w  = s1.w;
  assign uu = s1.uu;
  assign uv = s1.uv;
  assign uw = s1.uw;
  assign vv = s1.vv;
  assign vw = s1.vw;
  assign ww = s1.ww;
  assign prod = pm(s1.p1, s1.c);

  always_comb begin
    s  = prod;
    g0 = '0;
    g1 = '0;
    g2 = '0;
    case (s1.ctl.fsel)
      F_LINE_E1: begin
        s  = (prod + 2) >>> 2;
        g0 = -QUARTER + ((3 * uu + 2) >>> 2);
      end
      F_TRI_E1: begin
        g0 = ONE - 6 * u - 2 * v + 6 * uu + 6 * uv + vv;
        g1 = -2 * u + 3 * uu + 2 * uv;
      end
      F_TRI_E2: begin
        g0 = -2 * v + 2 * uv + 3 * vv;
        g1 = ONE - 2 * u - 6 * v + uu + 6 * uv + 6 * vv;
      end
      F_TRI_E3, F_TET_E4: begin
        g0 = 2 * uv - vv;
        g1 = uu - 2 * uv;
      end
      F_TET_E1: begin
        g0 = ONE - 6 * u - 2 * v - 2 * w + 6 * uu + 6 * uv + 6 * uw
             + vv + 2 * vw + ww;
        g1 = -2 * u + 3 * uu + 2 * uv + 2 * uw;
        g2 = -2 * u + 3 * uu + 2 * uv + 2 * uw;
      end
      F_TET_E2: begin
        g0 = -2 * v + 2 * uv + 3 * vv + 2 * vw;
        g1 = ONE - 2 * u - 6 * v - 2 * w + uu + 6 * uv + 2 * uw
             + 6 * vv + 6 * vw + ww;
        g2 = -2 * v + 2 * uv + 3 * vv + 2 * vw;
      end
      F_TET_E3: begin
        g0 = -2 * w + 2 * uw + 2 * vw + 3 * ww;
        g1 = -2 * w + 2 * uw + 2 * vw + 3 * ww;
        g2 = ONE - 2 * u - 2 * v - 6 * w + uu + 2 * uv + 6 * uw
             + vv + 6 * vw + 6 * ww;
      end
      F_TET_E5: begin
        g0 = 2 * uw - ww;
        g2 = uu - 2 * uw;
      end
      F_TET_E6: begin
        g1 = 2 * vw - ww;
        g2 = vv - 2 * vw;
      end
      F_TRI_F1: begin
        g0 = v - 2 * uv - vv;
        g1 = u - uu - 2 * uv;
      end
      F_TET_F1: begin
        g0 = w - 2 * uw - vw - ww;
        g1 = -uw;
        g2 = u - uu - uv - 2 * uw;
      end
      F_TET_F2: begin
        g0 = v - 2 * uv - vv - vw;
        g1 = u - uu - 2 * uv - uw;
        g2 = -uv;
      end
      F_TET_F3: begin
        g0 = -vw;
        g1 = w - uw - 2 * vw - ww;
        g2 = v - uv - vv - 2 * vw;
      end
      default: begin
        g0 = vw;
        g1 = uw;
        g2 = uv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.ctl.valid <= 1'b0;
    end else begin
      s2.ctl.valid <= s1.ctl.valid;
    end
    s2.ctl.func   <= s1.ctl.func;
    s2.ctl.fsel   <= s1.ctl.fsel;
    s2.ctl.negate <= s1.ctl.negate;
    s2.ctl.status <= s1.ctl.status;
    s2.s  <= s;
    s2.g0 <= g0;
    s2.g1 <= g1;
    s2.g2 <= g2;
  end

endmodule

// File: hw/rtl/chbe_out.sv
// ----------------------------------------------------------------------------
// chbe_out
// third stage: reversal, output form selection and saturation
// ----------------------------------------------------------------------------
module chbe_out (
  input  logic             clk,
  input  logic             rst,
  input  chbe_pkg::s2_t    s2,
  output logic             valid,
  output chbe_pkg::comp_t  comp_x,
  output chbe_pkg::comp_t  comp_y,
  output chbe_pkg::comp_t  comp_z,
  output logic [1:0]       status,
  output logic             saturated
);
  import chbe_pkg::*;

  wide_t s, g0, g1, g2, c0, c1, c2;
  comp_t k0, k1, k2;
  logic  sat0, sat1, sat2;

  function automatic comp_t clip(wide_t x);
    if (x > OUT_MAX) return comp_t'(OUT_MAX);
    if (x < OUT_MIN) return comp_t'(OUT_MIN);
    return comp_t'(x);
  endfunction

  always_comb begin
    s  = s2.ctl.negate ? -s2.s  : s2.s;
    g0 = s2.ctl.negate ? -s2.g0 : s2.g0;
    g1 = s2.ctl.negate ? -s2.g1 : s2.g1;
    g2 = s2.ctl.negate ? -s2.g2 : s2.g2;
    c0 = '0;
    c1 = '0;
    c2 = '0;
    case (s2.ctl.func)
      FUNC_VALUE, FUNC_X: c0 = s;
      FUNC_GRAD: begin c0 = g0; c1 = g1; c2 = g2; end
      FUNC_CURL: begin c0 = g1; c1 = -g0; c2 = g2; end
      FUNC_Y: c1 = s;
      default: c2 = s;
    endcase
    if (s2.ctl.status != ST_OK) begin
      c0 = '0;
      c1 = '0;
      c2 = '0;
    end
    k0   = clip(c0);
    k1   = clip(c1);
    k2   = clip(c2);
    sat0 = c0 > OUT_MAX || c0 < OUT_MIN;
    sat1 = c1 > OUT_MAX || c1 < OUT_MIN;
    sat2 = c2 > OUT_MAX || c2 < OUT_MIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= s2.ctl.valid;
    end
    comp_x    <= k0;
    comp_y    <= k1;
    comp_z    <= k2;
    status    <= s2.ctl.status;
    saturated <= sat0 | sat1 | sat2;
  end

endmodule

// File: hw/rtl/cubic_hierarchical_basis_eval_core.sv
// throughput: one beat per cycle, start may be high in every cycle
// three register stages: squares and first product, second product and
// gradient sums, then sign, form select and saturation
// busy is always low; the receiver cannot stall, so no beat is ever held back
// rst (synchronous) clears the stage valid bits; no result follows it
// ----------------------------------------------------------------------------
// cubic_hierarchical_basis_eval_core
// pipelined degree-3 hierarchical basis evaluator for line, triangle, tetrahedron
// ----------------------------------------------------------------------------
module cubic_hierarchical_basis_eval_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       func,
  input  logic [2:0]       element_type,
  input  logic [1:0]       entity_kind,
  input  logic [2:0]       entity_number,
  input  logic             edge_reversed,
  input  chbe_pkg::coord_t coord_u,
  input  chbe_pkg::coord_t coord_v,
  input  chbe_pkg::coord_t coord_w,
  output logic             valid,
  output chbe_pkg::comp_t  comp_x,
  output chbe_pkg::comp_t  comp_y,
  output chbe_pkg::comp_t  comp_z,
  output logic [1:0]       status,
  output logic             saturated
);
  import chbe_pkg::*;

  s1_t s1;
  s2_t s2;

  assign busy = 1'b0;

  chbe_prod u_prod (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .func          (func),
    .element_type  (element_type),
    .entity_kind   (entity_kind),
    .entity_number (entity_number),
    .edge_reversed (edge_reversed),
    .coord_u       (coord_u),
    .coord_v       (coord_v),
    .coord_w       (coord_w),
    .s1            (s1)
  );

  chbe_grad u_grad (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s2  (s2)
  );

  chbe_out u_out (
    .clk       (clk),
    .rst       (rst),
    .s2        (s2),
    .valid     (valid),
    .comp_x    (comp_x),
    .comp_y    (comp_y),
    .comp_z    (comp_z),
    .status    (status),
    .saturated (saturated)
  );

endmodule

// File: hw/rtl/chbe_checker.sv
// ----------------------------------------------------------------------------
// chbe_checker
// port-level checks of the basis evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chbe_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic [2:0]       func,
  input logic [2:0]       element_type,
  input logic [1:0]       entity_kind,
  input logic [2:0]       entity_number,
  input logic             edge_reversed,
  input chbe_pkg::coord_t coord_u,
  input chbe_pkg::coord_t coord_v,
  input chbe_pkg::coord_t coord_w,
  input logic             valid,
  input chbe_pkg::comp_t  comp_x,
  input chbe_pkg::comp_t  comp_y,
  input chbe_pkg::comp_t  comp_z,
  input logic [1:0]       status,
  input logic             saturated
);
  import chbe_pkg::*;

  // every accepted beat comes out on valid after the stage registers, and nothing else does
  `ASSERT_DELAYED(a_beat_out, start && !busy, 3, valid)
  `ASSERT_DELAYED(a_no_phantom, !start, 3, !valid)
  // error results are all zero and never flagged as clipped
  `ASSERT_IMPLIES(a_err_zero, valid && status != ST_OK,
                  comp_x == '0 && comp_y == '0 && comp_z == '0 && !saturated)
  // a bad element type always reports unsupported
  `ASSERT_DELAYED(a_unsupp, start && !(element_type == ELEM_LINE ||
                  element_type == ELEM_TRI || element_type == ELEM_TET), 3,
                  status == ST_UNSUPP)

endmodule

bind cubic_hierarchical_basis_eval_core chbe_checker u_chbe_checker (.*);
